### design/swac_pkg.sv
package swac_pkg;

    localparam int COLUMNS_DEF = 320;
    localparam int ROWS_DEF    = 128;
    localparam int BINS_DEF    = 512;

    localparam logic [8:0]  MIN_BIN_RST = 9'd0;
    localparam logic [8:0]  MAX_BIN_RST = 9'd511;
    localparam logic [15:0] DECAY_RST   = 16'd64881;

    // action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_DRAW = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MIN_BIN = 2'd0;
    localparam logic [1:0] REG_MAX_BIN = 2'd1;
    localparam logic [1:0] REG_DECAY   = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [8:0]  bin_index;
        logic [15:0] magnitude;
        logic [6:0]  row;
        logic [8:0]  column;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  color;
        logic [15:0] peak_level;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAX_ADDR,
        ST_MAX_RD,
        ST_MAX_CMP,
        ST_PEAK,
        ST_COL_ADDR,
        ST_COL_RD,
        ST_COL_CLS,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_OUT
    } t_state;

endpackage

### design/spectrum_waterfall_agc_colorizer.sv
// Sequence: o_valid is registered and rises on leaving the output state. A load or an unused
//   action goes there straight from idle, a pixel read through the address and wait states.
// Flow: one item at a time, accepted in the idle state only. A frame makes two column walks
//   (address, read, then compare or classify for each column) with the peak update between.
//   A result not yet taken holds the next item in the output state until it is taken.
// Reset: synchronous, active low; then a clearing pass writes black into every pixel of the
//   waterfall memory, during which no item is accepted.
module spectrum_waterfall_agc_colorizer
    import swac_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    parameter int BINS    = BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BW  = $clog2(BINS);
    localparam int PIX = ROWS * COLUMNS;
    localparam int AW  = $clog2(PIX);
    localparam logic [CW:0] COLS_L = (CW+1)'(COLUMNS);
    localparam logic [RW:0] ROWS_L = (RW+1)'(ROWS);
    // reciprocal of COLUMNS, exact for every product col*span below COLUMNS*512
    localparam int DIV_SH = 29;
    localparam logic [DIV_SH:0] COL_RECIP =
        (DIV_SH+1)'(((64'd1 << DIV_SH) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));

    // configuration
    logic [8:0]  r_min_bin, r_max_bin;
    logic [15:0] r_decay;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bin <= MIN_BIN_RST;
            r_max_bin <= MAX_BIN_RST;
            r_decay   <= DECAY_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MIN_BIN: r_min_bin <= pwdata[8:0];
                REG_MAX_BIN: r_max_bin <= pwdata[8:0];
                REG_DECAY:   r_decay   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MIN_BIN: prdata = {23'd0, r_min_bin};
            REG_MAX_BIN: prdata = {23'd0, r_max_bin};
            REG_DECAY:   prdata = {16'd0, r_decay};
            default:     prdata = 32'd0;
        endcase
    end

    // datapath registers
    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [CW:0] r_col, n_col;
    logic [CW+9:0] r_cs, n_cs;          // running col*span
    logic [AW:0] r_clr, n_clr;
    logic [15:0] r_fmax, n_fmax;
    logic [15:0] r_peak, n_peak;
    logic [RW-1:0] r_wptr, n_wptr;
    logic [BW-1:0] r_bidx, n_bidx;
    logic [AW-1:0] r_base, n_base;
    logic [31:0] r_prod, n_prod;
    t_out_item   r_out, n_out;
    logic        r_ov, n_ov;

    // memories
    logic [15:0] bin_mem [BINS];
    logic [2:0]  wf_mem  [PIX];
    logic        bin_we, wf_we;
    logic [BW-1:0] bin_waddr, bin_raddr;
    logic [AW-1:0] wf_waddr, wf_raddr;
    logic [2:0]    wf_wdata;
    logic [15:0]   r_bin_q;
    logic [2:0]    r_wf_q;

    always_ff @(posedge i_clk) begin
        if (bin_we) bin_mem[bin_waddr] <= r_item.magnitude;
        r_bin_q <= bin_mem[bin_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (wf_we) wf_mem[wf_waddr] <= wf_wdata;
        r_wf_q <= wf_mem[wf_raddr];
    end

    // shared multiplier, combinational; its products are registered in r_prod and r_base
    logic [16:0] mul_a, mul_b;
    logic [33:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // column to bin mapping: min + col*span/COLUMNS
    logic [8:0]  span;
    logic [CW+DIV_SH+10:0] cprod;
    logic [CW+9:0] cdiv;
    logic [9:0]  bsum;
    assign span  = (r_max_bin > r_min_bin) ? (r_max_bin - r_min_bin) : 9'd0;
    assign cprod = (CW+DIV_SH+11)'(r_cs) * (CW+DIV_SH+11)'(COL_RECIP);
    assign cdiv  = (CW+10)'(cprod >> DIV_SH);
    assign bsum  = 10'(r_min_bin) + 10'(cdiv);

    // peak as threshold base
    logic [16:0] pval;
    assign pval = (r_peak == 16'd0) ? 17'h10000 : {1'b0, r_peak};

    logic [35:0] lhs;
    logic [6:0]  kth;
    logic [2:0]  lvl;
    assign lhs = 36'(r_bin_q) * 36'd500;
    always_comb begin
        lvl = 3'd0;
        for (int k = 4; k >= 0; k--) begin
            case (k)
                0: kth = 7'd75;
                1: kth = 7'd50;
                2: kth = 7'd25;
                3: kth = 7'd10;
                default: kth = 7'd5;
            endcase
            if (lhs > 36'(kth) * 36'(pval)) lvl = 3'(5 - k);
        end
    end

    logic [RW:0] phys;
    assign phys = (RW+1)'(r_wptr) + (RW+1)'(1) + (RW+1)'(r_item.row);

    always_comb begin
        n_state = r_state; n_col = r_col; n_cs = r_cs; n_clr = r_clr; n_fmax = r_fmax;
        n_peak = r_peak; n_wptr = r_wptr;
        n_bidx = r_bidx; n_base = r_base; n_prod = r_prod; n_out = r_out; n_ov = r_ov;
        bin_we = 1'b0; bin_waddr = r_item.bin_index[BW-1:0];
        bin_raddr = r_bidx;
        wf_we = 1'b0; wf_waddr = r_clr[AW-1:0]; wf_wdata = 3'd0;
        wf_raddr = r_base;
        mul_a = {1'b0, r_peak}; mul_b = {1'b0, r_decay};
        o_ready = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                wf_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(PIX - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_item.action)
                        ACT_LOAD: n_state = ST_OUT;
                        ACT_DRAW: begin
                            n_col = '0; n_cs = '0; n_fmax = 16'd0; n_state = ST_MAX_ADDR;
                        end
                        ACT_READ: n_state = ST_RD_ADDR;
                        default:  n_state = ST_OUT;
                    endcase
                end
            end
            ST_MAX_ADDR: begin
                n_bidx = bsum[BW-1:0] ;
                n_state = ST_MAX_RD;
            end
            ST_MAX_RD: n_state = ST_MAX_CMP;
            ST_MAX_CMP: begin
                if (r_bin_q > r_fmax) n_fmax = r_bin_q;
                if (r_col == COLS_L - 1'b1) begin
                    n_state = ST_PEAK;
                    n_prod = mul_p[31:0];
                end else begin
                    n_col = r_col + 1'b1; n_cs = r_cs + (CW+10)'(span);
                    n_state = ST_MAX_ADDR;
                end
            end
            ST_PEAK: begin
                if (r_fmax > r_peak) n_peak = r_fmax;
                else n_peak = r_prod[31:16];
                n_wptr = (RW'(r_wptr) == RW'(ROWS - 1)) ? '0 : r_wptr + 1'b1;
                n_col = '0;
                n_cs = '0;
                n_state = ST_COL_ADDR;
            end
            ST_COL_ADDR: begin
                n_bidx = bsum[BW-1:0];
                mul_a = 17'(r_wptr); mul_b = 17'(COLUMNS);
                n_base = AW'(mul_p);
                n_state = ST_COL_RD;
            end
            ST_COL_RD: n_state = ST_COL_CLS;
            ST_COL_CLS: begin
                wf_we = 1'b1;
                wf_waddr = r_base + AW'(r_col);
                wf_wdata = lvl;
                if (r_col == COLS_L - 1'b1) n_state = ST_OUT;
                else begin
                    n_col = r_col + 1'b1; n_cs = r_cs + (CW+10)'(span);
                    n_state = ST_COL_ADDR;
                end
            end
            ST_RD_ADDR: begin
                mul_a = 17'((phys >= ROWS_L) ? phys - ROWS_L : phys);
                mul_b = 17'(COLUMNS);
                n_base = AW'(mul_p[AW-1:0] + 34'(r_item.column));
                n_state = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                wf_raddr = r_base;
                n_state = ST_OUT;
            end
            // result goes out once the previous one has been taken
            ST_OUT: begin
                if (!r_ov || i_ready) begin
                    if (r_item.action == ACT_LOAD && 32'(r_item.bin_index) < BINS)
                        bin_we = 1'b1;
                    n_out.color = 3'd0;
                    if (r_item.action == ACT_READ && 32'(r_item.row) < ROWS
                        && 32'(r_item.column) < COLUMNS)
                        n_out.color = r_wf_q;
                    n_out.peak_level = r_peak;
                    n_ov = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_peak  <= 16'd0;
            r_wptr  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_peak  <= n_peak;
            r_wptr  <= n_wptr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) r_item <= i_item;
        r_col <= n_col; r_cs <= n_cs; r_fmax <= n_fmax; r_bidx <= n_bidx;
        r_base <= n_base; r_prod <= n_prod;
        r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.color <= 3'd5)) else $error("colour out of range");
    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wptr) < ROWS)) else $error("row pointer out of range");
`endif

endmodule

### tb/tb_spectrum_waterfall_agc_colorizer.sv
`timescale 1ns / 1ps

module tb_spectrum_waterfall_agc_colorizer;
    import swac_pkg::*;

    localparam int NCOL  = COLUMNS_DEF;
    localparam int NROW  = ROWS_DEF;
    localparam int NBIN  = BINS_DEF;
    localparam int WDOG_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spectrum_waterfall_agc_colorizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock, 2 ns period
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // shadow state of the display
    logic [15:0] sh_bins [NBIN];
    bit          sh_bin_written [NBIN];
    logic [2:0]  sh_pixels [NROW*NCOL];
    logic [15:0] sh_peak;
    int unsigned sh_newest;
    logic [8:0]  sh_min_bin;
    logic [8:0]  sh_max_bin;
    logic [15:0] sh_decay;

    t_in_item  pending_items [$];
    t_out_item expected_pixels [$];

    int  mismatches;
    int  stall_cycles;
    bit  rx_enable_gaps;
    bit  in_fire;
    longint wdog;

    function automatic logic [15:0] column_mag(int unsigned c);
        int unsigned span;
        int unsigned b;
        span = (sh_max_bin > sh_min_bin) ? (sh_max_bin - sh_min_bin) : 0;
        b = sh_min_bin + (c * span) / NCOL;
        return sh_bins[b % NBIN];
    endfunction

    function automatic logic [2:0] colour_level(logic [15:0] m, longint unsigned p);
        longint unsigned lhs;
        lhs = 500 * longint'(m);
        if (lhs > 75 * p) return 3'd5;
        if (lhs > 50 * p) return 3'd4;
        if (lhs > 25 * p) return 3'd3;
        if (lhs > 10 * p) return 3'd2;
        if (lhs > 5 * p)  return 3'd1;
        return 3'd0;
    endfunction

    // advance the shadow display by one item and queue its result
    task automatic predict_item(t_in_item it);
        t_out_item res;
        logic [15:0] fmax;
        logic [15:0] m;
        longint unsigned p;
        int unsigned phys;
        res.color = 3'd0;
        case (it.action)
            ACT_LOAD: begin
                sh_bins[it.bin_index] = it.magnitude;
                sh_bin_written[it.bin_index] = 1'b1;
            end
            ACT_DRAW: begin
                fmax = 16'd0;
                for (int c = 0; c < NCOL; c++) begin
                    m = column_mag(c);
                    if (m > fmax) fmax = m;
                end
                if (fmax > sh_peak) sh_peak = fmax;
                else sh_peak = 16'((longint'(sh_peak) * sh_decay) >> 16);
                p = (sh_peak != 0) ? sh_peak : 65536;
                sh_newest = (sh_newest + 1) % NROW;
                for (int c = 0; c < NCOL; c++)
                    sh_pixels[sh_newest*NCOL + c] = colour_level(column_mag(c), p);
            end
            ACT_READ: begin
                if (it.row < NROW && it.column < NCOL) begin
                    phys = (sh_newest + 1 + it.row) % NROW;
                    res.color = sh_pixels[phys*NCOL + it.column];
                end
            end
            default: ;
        endcase
        res.peak_level = sh_peak;
        expected_pixels.push_back(res);
    endtask

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // driver: one item offered from the queue, held until accepted
    int tx_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (i_valid && !in_fire) begin
            // hold
        end else if (tx_gap > 0) begin
            i_valid <= 1'b0;
            tx_gap  <= tx_gap - 1;
        end else if (pending_items.size() > 0) begin
            i_item  <= pending_items.pop_front();
            i_valid <= 1'b1;
            tx_gap  <= short_or_long_gap();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // prediction at acceptance, in the monitor's sampling edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) predict_item(i_item);
    end

    // receiver ready: random stalls, plus a long forced hold-off
    int rx_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap  <= 0;
        end else if (stall_cycles > 0) begin
            i_ready      <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else if (rx_gap > 0) begin
            i_ready <= 1'b0;
            rx_gap  <= rx_gap - 1;
        end else begin
            i_ready <= 1'b1;
            if (rx_enable_gaps) rx_gap <= short_or_long_gap();
        end
    end

    // monitor: check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: color=%0d peak=%0d",
                             o_item.color, o_item.peak_level);
            end else begin
                want = expected_pixels.pop_front();
                if (o_item.color !== want.color || o_item.peak_level !== want.peak_level) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: color exp %0d got %0d, peak exp %0d got %0d",
                                 want.color, o_item.color, want.peak_level, o_item.peak_level);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (psel && penable)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_BIN: sh_min_bin = val[8:0];
            REG_MAX_BIN: sh_max_bin = val[8:0];
            REG_DECAY:   sh_decay   = val[15:0];
            default: ;
        endcase
    endtask

    // wait until the block has answered everything sent so far
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(logic [1:0] act, int b, int mag, int r, int c);
        t_in_item it;
        it.action    = act;
        it.bin_index = 9'(b);
        it.magnitude = 16'(mag);
        it.row       = 7'(r);
        it.column    = 9'(c);
        return it;
    endfunction

    function automatic t_in_item random_read();
        int c;
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, NCOL-1);
        return make_item(ACT_READ, $urandom, $urandom, $urandom_range(0, 127), c);
    endfunction

    // one frame: load every bin the current mapping touches that is still unwritten,
    // then draw
    task automatic queue_frame(int scale);
        int unsigned span;
        int unsigned b;
        span = (sh_max_bin > sh_min_bin) ? (sh_max_bin - sh_min_bin) : 0;
        for (int c = 0; c < NCOL; c++) begin
            b = (sh_min_bin + (c * span) / NCOL) % NBIN;
            if (!sh_bin_written[b]) begin
                pending_items.push_back(make_item(ACT_LOAD, b,
                                        $urandom_range(0, scale), $urandom, $urandom));
                sh_bin_written[b] = 1'b1;
            end
        end
        pending_items.push_back(make_item(ACT_DRAW, $urandom, $urandom, $urandom, $urandom));
    endtask

    initial begin
        int frames;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_item  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; stall_cycles = 0; rx_enable_gaps = 1'b0;
        wdog = 0;
        sh_peak = 0; sh_newest = 0;
        sh_min_bin = MIN_BIN_RST; sh_max_bin = MAX_BIN_RST; sh_decay = DECAY_RST;
        for (int i = 0; i < NBIN; i++) begin
            sh_bins[i] = 0;
            sh_bin_written[i] = 1'b0;
        end
        for (int i = 0; i < NROW*NCOL; i++) sh_pixels[i] = 3'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reads of the black screen, loads at the extremes, unused action
        pending_items.push_back(make_item(ACT_READ, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_READ, 511, 65535, 127, 319));
        pending_items.push_back(make_item(ACT_READ, 0, 0, 5, 511));
        pending_items.push_back(make_item(2'd3, 511, 65535, 127, 511));
        pending_items.push_back(make_item(ACT_LOAD, 0, 65535, 0, 0));
        pending_items.push_back(make_item(ACT_LOAD, 511, 0, 127, 511));
        drain();

        // register extremes: empty span maps every column to the last bin;
        // decay 0 takes the peak to zero on the second frame
        write_reg(REG_MIN_BIN, 32'd511);
        write_reg(REG_MAX_BIN, 32'd0);
        write_reg(REG_DECAY, 32'd0);
        pending_items.push_back(make_item(ACT_LOAD, 511, 65535, 0, 0));
        pending_items.push_back(make_item(ACT_LOAD, 510, 1234, 0, 0));
        pending_items.push_back(make_item(ACT_DRAW, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_DRAW, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_DRAW, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_READ, 0, 0, 127, 0));
        pending_items.push_back(make_item(ACT_READ, 0, 0, 126, 319));
        drain();

        // one bin per column, maximum decay
        write_reg(REG_MIN_BIN, 32'd0);
        write_reg(REG_MAX_BIN, 32'd320);
        write_reg(REG_DECAY, 32'd65535);
        rx_enable_gaps = 1'b1;
        // hold off receiver while sender keeps offering
        stall_cycles = 300;
        queue_frame(65535);
        for (int i = 0; i < 10; i++) pending_items.push_back(random_read());
        drain();

        // random frames across several settings, the last one at full span
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 3) begin
                write_reg(REG_MIN_BIN, 32'd0);
                write_reg(REG_MAX_BIN, 32'd511);
                write_reg(REG_DECAY, 32'd64881);
            end else begin
                write_reg(REG_MIN_BIN, $urandom_range(0, 319));
                write_reg(REG_MAX_BIN, $urandom_range(0, 320));
                write_reg(REG_DECAY, $urandom_range(0, 65535));
            end
            frames = (ph == 3) ? 1 : 2;
            for (int f = 0; f < frames; f++) begin
                for (int k = 0; k < 4; k++)
                    pending_items.push_back(make_item(ACT_LOAD, $urandom,
                        (f == 1) ? $urandom_range(0, 200) : $urandom, $urandom, $urandom));
                queue_frame(65535);
                for (int k = 0; k < 4; k++) pending_items.push_back(random_read());
            end
            drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
